/* rtl/aft_pkg.sv */
package aft_pkg;

	localparam int ADDR_W    = 40;
	localparam int TIME_W    = 32;
	localparam int AGE_W     = 16;
	localparam int LEN_W     = 6;
	localparam int IDXO_W    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int IN_W      = 48;
	localparam int OUT_W     = 16;

	localparam logic [LEN_W-1:0] MIN_REJECT_LEN = 6'd11;
	localparam logic [AGE_W-1:0] AGE_RESET      = 16'd210;

	typedef enum logic [1:0] {
		OP_LEARN   = 2'd0,
		OP_REFRESH = 2'd1,
		OP_FORWARD = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ROUTE_NONE      = 3'd0,
		ROUTE_GATEWAY   = 3'd1,
		ROUTE_LOCAL     = 3'd2,
		ROUTE_DISCOVERY = 3'd3,
		ROUTE_RADIO     = 3'd4,
		ROUTE_DEFAULT   = 3'd5
	} route_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_GATEWAY   = 2'd0,
		CFG_LOCAL     = 2'd1,
		CFG_DISCOVERY = 2'd2,
		CFG_MAX_AGE   = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START,
		S_SCAN,
		S_FIN
	} state_t;

	// which result the datapath latches
	typedef enum logic [2:0] {
		RES_NONE,
		RES_CFG,
		RES_HIT,
		RES_MISS,
		RES_NEW,
		RES_FULL
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     scan_clr;
		logic     scan_en;
		logic     now_inc;
		logic     wr_hit;
		logic     wr_new;
		logic     res_load;
		res_sel_t res_sel;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic short_len;
		logic cfg_hit;
		logic hit;
		logic scan_done;
		logic tbl_full;
		logic out_free;
	} stat_t;

endpackage

/* rtl/aft_ctrl.sv */
module aft_ctrl
	import aft_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   s_tvalid,
	output logic   s_tready,
	input  stat_t  stat,
	output cmd_t   cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = S_START;
				end
			end
			S_START: begin
				unique case (stat.op)
					OP_TICK: begin
						cmd.now_inc  = 1'b1;
						cmd.res_load = 1'b1;
						cmd.res_sel  = RES_NONE;
						state_d      = S_FIN;
					end
					OP_FORWARD: begin
						if (stat.short_len) begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_NONE;
							state_d      = S_FIN;
						end else if (stat.cfg_hit) begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_CFG;
							state_d      = S_FIN;
						end else begin
							cmd.scan_clr = 1'b1;
							state_d      = S_SCAN;
						end
					end
					default: begin
						cmd.scan_clr = 1'b1;
						state_d      = S_SCAN;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan_en = 1'b1;
				if (stat.hit) begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_HIT;
					cmd.wr_hit   = (stat.op != OP_FORWARD);
					state_d      = S_FIN;
				end else if (stat.scan_done) begin
					cmd.res_load = 1'b1;
					if (stat.op == OP_LEARN) begin
						if (stat.tbl_full) begin
							cmd.res_sel = RES_FULL;
						end else begin
							cmd.res_sel = RES_NEW;
							cmd.wr_new  = 1'b1;
						end
					end else begin
						cmd.res_sel = RES_MISS;
					end
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* rtl/aft_dp.sv */
module aft_dp
	import aft_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [IN_W-1:0]      s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  cmd_t                 cmd,
	output stat_t                stat
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// configuration
	logic [ADDR_W-1:0] gateway_q, local_q, discovery_q;
	logic [AGE_W-1:0]  max_age_q;

	// item
	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;

	// table state
	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] addr_mem [TABLE_DEPTH];
	logic [TIME_W-1:0] time_mem [TABLE_DEPTH];

	// scan
	logic [CNT_W-1:0]  rd_ptr_q;
	logic              cmp_v_s1;
	logic [IDX_W-1:0]  cmp_idx_s1;
	logic [ADDR_W-1:0] rd_addr_s1;
	logic [TIME_W-1:0] rd_time_s1;

	// result and output
	route_t            res_route_q;
	logic              res_found_q;
	logic [IDXO_W-1:0] res_idx_q;
	logic              res_full_q;
	logic              out_v_q;
	logic [OUT_W-1:0]  out_q;

	logic              rd_en;
	logic [TIME_W-1:0] age;
	logic              fresh;
	logic              hit;
	logic [IDX_W-1:0]  new_idx;
	logic [IDX_W-1:0]  wr_idx;
	logic [IDX_W+IDXO_W-1:0] hit_idx_ext;
	logic [IDX_W+IDXO_W-1:0] new_idx_ext;
	route_t            cfg_route;

	assign rd_en   = cmd.scan_en && (rd_ptr_q < count_q);
	assign age     = now_q - rd_time_s1;
	assign fresh   = (age <= {{(TIME_W-AGE_W){1'b0}}, max_age_q});
	assign hit     = cmp_v_s1 && (rd_addr_s1 == addr_q) && ((op_q != OP_FORWARD) || fresh);
	assign new_idx = count_q[IDX_W-1:0];
	assign wr_idx  = cmd.wr_new ? new_idx : cmp_idx_s1;
	assign hit_idx_ext = {{IDXO_W{1'b0}}, cmp_idx_s1};
	assign new_idx_ext = {{IDXO_W{1'b0}}, new_idx};

	// address priority: gateway, local, discovery
	always_comb begin
		if (addr_q == gateway_q) begin
			cfg_route = ROUTE_GATEWAY;
		end else if (addr_q == local_q) begin
			cfg_route = ROUTE_LOCAL;
		end else if (addr_q == discovery_q) begin
			cfg_route = ROUTE_DISCOVERY;
		end else begin
			cfg_route = ROUTE_NONE;
		end
	end

	// status towards the controller
	always_comb begin
		stat.op        = op_q;
		stat.short_len = (len_q <= MIN_REJECT_LEN);
		stat.cfg_hit   = (cfg_route != ROUTE_NONE);
		stat.hit       = hit;
		stat.scan_done = !cmp_v_s1 && !(rd_ptr_q < count_q);
		stat.tbl_full  = (count_q == CNT_W'(TABLE_DEPTH));
		stat.out_free  = !out_v_q || m_tready;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gateway_q   <= '0;
			local_q     <= '0;
			discovery_q <= '0;
			max_age_q   <= AGE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_GATEWAY:   gateway_q   <= cfg_data;
				CFG_LOCAL:     local_q     <= cfg_data;
				CFG_DISCOVERY: discovery_q <= cfg_data;
				CFG_MAX_AGE:   max_age_q   <= cfg_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// capture the accepted beat
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(s_tdata[1:0]);
			addr_q <= s_tdata[ADDR_W+1:2];
			len_q  <= s_tdata[ADDR_W+LEN_W+1:ADDR_W+2];
		end
	end

	// seconds counter and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.now_inc) begin
				now_q <= now_q + 1'b1;
			end
			if (cmd.wr_new) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	// table write port
	always_ff @(posedge clk) begin
		if (cmd.wr_new) begin
			addr_mem[wr_idx] <= addr_q;
		end
		if (cmd.wr_new || cmd.wr_hit) begin
			time_mem[wr_idx] <= now_q;
		end
	end

	// table read port, registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_addr_s1 <= addr_mem[rd_ptr_q[IDX_W-1:0]];
			rd_time_s1 <= time_mem[rd_ptr_q[IDX_W-1:0]];
			cmp_idx_s1 <= rd_ptr_q[IDX_W-1:0];
		end
	end

	// scan pointer and compare-stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			cmp_v_s1 <= 1'b0;
		end else if (cmd.scan_clr) begin
			rd_ptr_q <= '0;
			cmp_v_s1 <= 1'b0;
		end else begin
			cmp_v_s1 <= rd_en;
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	// latch the result
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_route_q <= ROUTE_NONE;
			res_found_q <= 1'b0;
			res_idx_q   <= '0;
			res_full_q  <= 1'b0;
			unique case (cmd.res_sel)
				RES_CFG: begin
					res_route_q <= cfg_route;
				end
				RES_HIT: begin
					res_route_q <= (op_q == OP_FORWARD) ? ROUTE_RADIO : ROUTE_NONE;
					res_found_q <= 1'b1;
					res_idx_q   <= hit_idx_ext[IDXO_W-1:0];
				end
				RES_MISS: begin
					res_route_q <= (op_q == OP_FORWARD) ? ROUTE_DEFAULT : ROUTE_NONE;
				end
				RES_NEW: begin
					res_idx_q <= new_idx_ext[IDXO_W-1:0];
				end
				RES_FULL: begin
					res_full_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q <= {{(OUT_W-9){1'b0}}, res_full_q, res_idx_q, res_found_q, res_route_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_q;

endmodule

/* rtl/aging_forwarding_table.sv */
// Forwarding table with entry aging. Each input beat is a learn, refresh,
// forward or one-second tick, and yields exactly one result beat. Learn,
// refresh and forward (when the packet length is above 11 and the
// destination is not one of the three configured addresses) walk the table
// slots in order, one slot a cycle through a registered single-port read.
// One item is worked on at a time, but the next beat is taken while the
// previous result still waits in the output register. Registers, written
// through cfg_we/cfg_index/cfg_data: 0 gateway address, 1 local address,
// 2 discovery address, 3 maximum age in seconds (reset 210). The user must
// write them only while the block is idle; the block itself does not enforce it.
module aging_forwarding_table
	import aft_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [IN_W-1:0]      s_tdata,   // operation[1:0], dest_address[41:2], packet_length[47:42]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // route[2:0], found[3], entry_index[7:4], table_full[8]
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	cmd_t  cmd;
	stat_t stat;

	// sequencer
	aft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// table, counters and result path
	aft_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

/* test/aging_forwarding_table_test.sv */
module aging_forwarding_table_test;
	timeunit 1ns;
	timeprecision 1ps;

	import aft_pkg::*;

	localparam int DEPTH          = 16;
	localparam int POOL_SIZE      = 20;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		route_t            route;
		logic              found;
		logic [IDXO_W-1:0] slot;
		logic              full;
	} route_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_W-1:0]      s_tdata;   // operation[1:0], dest_address[41:2], packet_length[47:42]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [OUT_W-1:0]     m_tdata;   // route[2:0], found[3], entry_index[7:4], table_full[8]
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	// mirror of the block's registers and table
	logic [ADDR_W-1:0] gw_addr;
	logic [ADDR_W-1:0] own_addr;
	logic [ADDR_W-1:0] disc_addr;
	logic [AGE_W-1:0]  age_limit;
	logic [ADDR_W-1:0] nbr_addr [DEPTH];
	logic [TIME_W-1:0] nbr_seen [DEPTH];
	int                nbr_count;
	logic [TIME_W-1:0] seconds;

	route_result_t     pending_routes[$];
	logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
	int                mismatch_count = 0;
	int                idle_cycles = 0;
	bit                calm;

	aging_forwarding_table #(.TABLE_DEPTH(DEPTH)) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// first valid slot holding addr, optionally also within the age limit
	function automatic int find_neighbour(logic [ADDR_W-1:0] addr, bit check_age);
		logic [TIME_W-1:0] age;
		for (int k = 0; k < nbr_count; k++) begin
			age = seconds - nbr_seen[k];
			if (nbr_addr[k] == addr && !(check_age && age > age_limit))
				return k;
		end
		return -1;
	endfunction

	// work out the result of one beat and advance the mirrored state
	function automatic route_result_t predict_route(op_t op, logic [ADDR_W-1:0] addr,
			logic [LEN_W-1:0] len);
		route_result_t r;
		int slot;
		r = '{route: ROUTE_NONE, found: 1'b0, slot: '0, full: 1'b0};
		case (op)
			OP_LEARN: begin
				slot = find_neighbour(addr, 1'b0);
				if (slot >= 0) begin
					nbr_seen[slot] = seconds;
					r.found = 1'b1;
					r.slot = IDXO_W'(slot);
				end else if (nbr_count < DEPTH) begin
					nbr_addr[nbr_count] = addr;
					nbr_seen[nbr_count] = seconds;
					r.slot = IDXO_W'(nbr_count);
					nbr_count++;
				end else begin
					r.full = 1'b1;
				end
			end
			OP_REFRESH: begin
				slot = find_neighbour(addr, 1'b0);
				if (slot >= 0) begin
					nbr_seen[slot] = seconds;
					r.found = 1'b1;
					r.slot = IDXO_W'(slot);
				end
			end
			OP_FORWARD: begin
				if (len > MIN_REJECT_LEN) begin
					if (addr == gw_addr)
						r.route = ROUTE_GATEWAY;
					else if (addr == own_addr)
						r.route = ROUTE_LOCAL;
					else if (addr == disc_addr)
						r.route = ROUTE_DISCOVERY;
					else begin
						slot = find_neighbour(addr, 1'b1);
						if (slot >= 0) begin
							r.route = ROUTE_RADIO;
							r.found = 1'b1;
							r.slot = IDXO_W'(slot);
						end else begin
							r.route = ROUTE_DEFAULT;
						end
					end
				end
			end
			default: begin
				seconds = seconds + 1'b1;
			end
		endcase
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] any_address();
		return {8'($urandom_range(0, 255)), 32'($urandom())};
	endfunction

	function automatic logic [ADDR_W-1:0] pick_address();
		if ($urandom_range(0, 99) < 80)
			return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		return any_address();
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		if ($urandom_range(0, 99) < 75)
			return LEN_W'($urandom_range(12, 32));
		return LEN_W'($urandom_range(0, 11));
	endfunction

	function automatic op_t pick_op();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return OP_LEARN;
		if (r < 45)
			return OP_REFRESH;
		if (r < 85)
			return OP_FORWARD;
		return OP_TICK;
	endfunction

	// send one beat, with an occasional random gap in front of it
	task automatic send_item(op_t op, logic [ADDR_W-1:0] addr, logic [LEN_W-1:0] len);
		if (!calm && $urandom_range(0, 99) < 24) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {len, addr, op};
		do
			@(posedge clk);
		while (!s_tready);
		pending_routes.push_back(predict_route(op, addr, len));
	endtask

	// hold the sender until every result has come back
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_routes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [ADDR_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		case (idx)
			CFG_GATEWAY:   gw_addr = value;
			CFG_LOCAL:     own_addr = value;
			CFG_DISCOVERY: disc_addr = value;
			default:       age_limit = value[AGE_W-1:0];
		endcase
	endtask

	task automatic set_registers(logic [ADDR_W-1:0] gw, logic [ADDR_W-1:0] own,
			logic [ADDR_W-1:0] disc, logic [AGE_W-1:0] age);
		settle();
		write_reg(CFG_GATEWAY, gw);
		write_reg(CFG_LOCAL, own);
		write_reg(CFG_DISCOVERY, disc);
		write_reg(CFG_MAX_AGE, ADDR_W'(age));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// reset registers: all special addresses are zero, table empty
	task automatic check_reset_defaults();
		send_item(OP_FORWARD, '0, 6'd20);
		send_item(OP_FORWARD, addr_pool[2], 6'd12);
		send_item(OP_FORWARD, addr_pool[2], 6'd11);
		send_item(OP_FORWARD, addr_pool[2], 6'd0);
		send_item(OP_FORWARD, '1, 6'd32);
		send_item(OP_REFRESH, addr_pool[2], 6'd0);
		send_item(OP_TICK, '0, 6'd32);
	endtask

	// gateway wins over local, local over discovery
	task automatic check_address_priority();
		set_registers(addr_pool[3], addr_pool[3], addr_pool[3], AGE_RESET);
		send_item(OP_FORWARD, addr_pool[3], 6'd12);
		set_registers(addr_pool[4], addr_pool[3], addr_pool[3], AGE_RESET);
		send_item(OP_FORWARD, addr_pool[3], 6'd12);
		set_registers(addr_pool[4], addr_pool[4], addr_pool[3], AGE_RESET);
		send_item(OP_FORWARD, addr_pool[3], 6'd12);
		set_registers('1, '0, '1, AGE_RESET);
		send_item(OP_FORWARD, '1, 6'd31);
		send_item(OP_FORWARD, '0, 6'd31);
	endtask

	// insert, refresh and let entries go stale
	task automatic check_learn_and_aging();
		set_registers(addr_pool[3], addr_pool[4], addr_pool[5], 16'd2);
		send_item(OP_LEARN, addr_pool[6], 6'd0);
		send_item(OP_LEARN, addr_pool[6], 6'd0);
		send_item(OP_LEARN, addr_pool[7], 6'd0);
		send_item(OP_FORWARD, addr_pool[6], 6'd12);
		repeat (3) send_item(OP_TICK, '0, 6'd0);
		send_item(OP_FORWARD, addr_pool[6], 6'd12);
		send_item(OP_REFRESH, addr_pool[6], 6'd0);
		send_item(OP_FORWARD, addr_pool[6], 6'd12);
		send_item(OP_REFRESH, addr_pool[8], 6'd0);
		set_registers(addr_pool[3], addr_pool[4], addr_pool[5], 16'd0);
		send_item(OP_TICK, '0, 6'd0);
		send_item(OP_FORWARD, addr_pool[7], 6'd20);
		send_item(OP_LEARN, addr_pool[7], 6'd0);
		send_item(OP_FORWARD, addr_pool[7], 6'd20);
	endtask

	task automatic run_traffic(int count);
		repeat (count)
			send_item(pick_op(), pick_address(), pick_length());
	endtask

	// fill every slot, then try to add more
	task automatic check_table_full();
		settle();
		while (nbr_count < DEPTH)
			send_item(OP_LEARN, any_address(), pick_length());
		send_item(OP_LEARN, any_address(), 6'd0);
		send_item(OP_LEARN, any_address(), 6'd63);
		send_item(OP_LEARN, nbr_addr[DEPTH-1], 6'd0);
		send_item(OP_REFRESH, nbr_addr[DEPTH-1], 6'd0);
		send_item(OP_FORWARD, nbr_addr[DEPTH-1], 6'd32);
	endtask

	// receiver stalls at random except during the calm stretch
	always @(posedge clk)
		m_tready <= calm || ($urandom_range(0, 99) >= 24);

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : result_check
		route_result_t want;
		route_result_t got;
		if (m_tvalid && m_tready) begin
			got = '{route: route_t'(m_tdata[2:0]), found: m_tdata[3], slot: m_tdata[7:4],
				full: m_tdata[8]};
			if (pending_routes.size() == 0) begin
				if (mismatch_count < REPORT_LIMIT)
					$display("%0t: result beat with none expected: %h", $realtime, m_tdata);
				mismatch_count++;
			end else begin
				want = pending_routes.pop_front();
				if (got.route !== want.route || got.found !== want.found ||
						got.slot !== want.slot || got.full !== want.full) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("%0t: mismatch route %0d/%0d found %0d/%0d slot %0d/%0d full %0d/%0d",
							$realtime, want.route, got.route, want.found, got.found,
							want.slot, got.slot, want.full, got.full);
					mismatch_count++;
				end
			end
		end
	end

	// end the run when nothing has moved for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("aging_forwarding_table_test: FAIL");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_GATEWAY;
		cfg_data = '0;
		calm = 1'b0;
		gw_addr = '0;
		own_addr = '0;
		disc_addr = '0;
		age_limit = AGE_RESET;
		nbr_count = 0;
		seconds = '0;
		addr_pool[0] = '0;
		addr_pool[1] = '1;
		for (int k = 2; k < POOL_SIZE; k++)
			addr_pool[k] = any_address();

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		check_reset_defaults();
		check_address_priority();
		check_learn_and_aging();

		set_registers(addr_pool[0], addr_pool[1], addr_pool[2], AGE_RESET);
		run_traffic(100);
		set_registers('1, addr_pool[9], addr_pool[10], 16'd0);
		run_traffic(100);
		set_registers(addr_pool[11], '0, addr_pool[12], 16'hFFFF);
		calm = 1'b1;
		run_traffic(100);
		calm = 1'b0;
		set_registers(addr_pool[13], addr_pool[14], '1, 16'd4);
		run_traffic(100);
		check_table_full();

		// drain and let any stray beat show up
		s_tvalid <= 1'b0;
		while (pending_routes.size() != 0)
			@(posedge clk);
		repeat (DEPTH + 8) @(posedge clk);
		if (mismatch_count == 0 && pending_routes.size() == 0)
			$display("aging_forwarding_table_test: PASS");
		else
			$display("aging_forwarding_table_test: FAIL");
		$finish;
	end

endmodule

/* aging_forwarding_table.f */
rtl/aft_pkg.sv
rtl/aft_ctrl.sv
rtl/aft_dp.sv
rtl/aging_forwarding_table.sv
test/aging_forwarding_table_test.sv
